// ----- hw/rtl/lip_com_state_eval_defines.svh -----
// ----------------------------------------------------------------------------
// lip_com_state_eval_defines.svh
// Assertion macros for the verification-side checker of the block.
// ----------------------------------------------------------------------------
`ifndef LIP_COM_STATE_EVAL_DEFINES_SVH
`define LIP_COM_STATE_EVAL_DEFINES_SVH

// same-cycle implication, clocked on clk, masked while rst is high
`define LCSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clk, masked while rst is high
`define LCSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lcse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_pkg
// Types, constants and helper functions for the pendulum state evaluator.
// ----------------------------------------------------------------------------
package lcse_pkg;

   // fixed field widths
   localparam int EL_W      = 17;
   localparam int TC_W      = 16;
   localparam int IT_W      = 24;
   localparam int CFG_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int REG_FRAC  = 16;
   localparam int ANG_FRAC  = 30;
   localparam int ACC_W     = 32;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_CONST        = 2'd0,
      CSR_INV_TIME_CONST    = 2'd1,
      CSR_INV_TIME_CONST_SQ = 2'd2
   } csr_idx_type;

   localparam logic [TC_W-1:0] TC_RST   = 16'd14800;
   localparam logic [IT_W-1:0] ITC_RST  = 24'd290141;
   localparam logic [IT_W-1:0] ITSQ_RST = 24'd1284506;

   // range reduction: u = k*ln2 + r, all in Q30
   localparam int U_W    = EL_W + IT_W - REG_FRAC;   // time argument before reduction
   localparam int Z30_W  = U_W + ANG_FRAC - REG_FRAC;
   localparam int K_W    = 10;                       // k stays below 740
   localparam int KL_W   = K_W + ANG_FRAC;
   localparam int KDIV_SHIFT = 40;
   localparam int KDIV_W     = 25;
   localparam longint LN2_Q30 = 64'd744261118;
   localparam logic [KDIV_W-1:0] KDIV_MUL =
      KDIV_W'((64'd1 << (KDIV_SHIFT + ANG_FRAC - REG_FRAC)) / 64'd744261118);

   // CORDIC datapath
   localparam int Z_W = 34;
   localparam longint GAIN_INV_Q30 = 64'd1296540104;

   // saturation limits of the wide terms
   localparam int WL_W  = 39;
   localparam int DT_W  = 35;
   localparam longint WIDE_LIM = (64'sd1 <<< 38) - 64'sd1;
   localparam longint DT_LIM   = (64'sd1 <<< 34) - 64'sd1;

   // shift index of CORDIC iteration n: 1,2,3,4,4,5,..,13,13,..
   function automatic int cordic_shift(input int n);
      int idx;
      int rep;
      bit again;
      idx   = 1;
      rep   = 4;
      again = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (idx == rep && !again) begin
            again = 1'b1;
         end else begin
            if (idx == rep) begin
               rep   = 3 * rep + 1;
               again = 1'b0;
            end
            idx++;
         end
      end
      return idx;
   endfunction

   // atanh(2^-i) in Q30
   function automatic logic signed [Z_W-1:0] cordic_angle(input int i);
      logic signed [Z_W-1:0] a;
      case (i)
         1:       a = 34'sd589812981;
         2:       a = 34'sd274247419;
         3:       a = 34'sd134923406;
         4:       a = 34'sd67196451;
         5:       a = 34'sd33565361;
         6:       a = 34'sd16778582;
         7:       a = 34'sd8388779;
         8:       a = 34'sd4194325;
         9:       a = 34'sd2097155;
         default: a = (i > 30) ? '0 : (34'sd1 <<< (ANG_FRAC - i));
      endcase
      return a;
   endfunction

endpackage

// ----- hw/rtl/lcse_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_req_if
// Request channel: step-start state, pivot and elapsed time.
// ----------------------------------------------------------------------------
interface lcse_req_if import lcse_pkg::*; #(
   parameter int DATA_WIDTH = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] start_pos_x;
   logic signed [DATA_WIDTH-1:0] start_pos_y;
   logic signed [DATA_WIDTH-1:0] start_vel_x;
   logic signed [DATA_WIDTH-1:0] start_vel_y;
   logic signed [DATA_WIDTH-1:0] pivot_x;
   logic signed [DATA_WIDTH-1:0] pivot_y;
   logic        [EL_W-1:0]       elapsed;

   modport source (output valid, start_pos_x, start_pos_y, start_vel_x, start_vel_y,
                   pivot_x, pivot_y, elapsed, input ready);
   modport sink   (input valid, start_pos_x, start_pos_y, start_vel_x, start_vel_y,
                   pivot_x, pivot_y, elapsed, output ready);
endinterface

// ----- hw/rtl/lcse_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_rsp_if
// Response channel: propagated position, velocity and acceleration.
// ----------------------------------------------------------------------------
interface lcse_rsp_if import lcse_pkg::*; #(
   parameter int DATA_WIDTH = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] pos_x;
   logic signed [DATA_WIDTH-1:0] pos_y;
   logic signed [DATA_WIDTH-1:0] vel_x;
   logic signed [DATA_WIDTH-1:0] vel_y;
   logic signed [ACC_W-1:0]      acc_x;
   logic signed [ACC_W-1:0]      acc_y;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, input ready);
   modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, output ready);
endinterface

// ----- hw/rtl/lcse_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_cordic
// Pipelined hyperbolic CORDIC, one iteration per register stage, rotation mode.
// ----------------------------------------------------------------------------
module lcse_cordic import lcse_pkg::*; #(
   parameter int STAGES = 18,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic [STAGES-1:0]     ce,
   input  logic signed [Z_W-1:0] z_in,
   input  logic [SIDE_W-1:0]     side_in,
   output logic signed [Z_W-1:0] x_out,
   output logic signed [Z_W-1:0] y_out,
   output logic [SIDE_W-1:0]     side_out
);

   logic signed [Z_W-1:0] x_ff [STAGES];
   logic signed [Z_W-1:0] y_ff [STAGES];
   logic signed [Z_W-1:0] z_ff [STAGES];
   logic [SIDE_W-1:0]     side_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int SH = cordic_shift(s);
      localparam logic signed [Z_W-1:0] ANG = cordic_angle(SH);

      logic signed [Z_W-1:0] x_prev, y_prev, z_prev;
      logic [SIDE_W-1:0]     side_prev;

      if (s == 0) begin : g_first
         assign x_prev    = Z_W'(GAIN_INV_Q30);
         assign y_prev    = '0;
         assign z_prev    = z_in;
         assign side_prev = side_in;
      end else begin : g_next
         assign x_prev    = x_ff[s-1];
         assign y_prev    = y_ff[s-1];
         assign z_prev    = z_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // one micro-rotation, direction from the residual angle sign
      always_ff @(posedge clock) begin
         if (ce[s]) begin
            if (z_prev >= 0) begin
               x_ff[s] <= x_prev + (y_prev >>> SH);
               y_ff[s] <= y_prev + (x_prev >>> SH);
               z_ff[s] <= z_prev - ANG;
            end else begin
               x_ff[s] <= x_prev - (y_prev >>> SH);
               y_ff[s] <= y_prev - (x_prev >>> SH);
               z_ff[s] <= z_prev + ANG;
            end
            side_ff[s] <= side_prev;
         end
      end
   end

   assign x_out    = x_ff[STAGES-1];
   assign y_out    = y_ff[STAGES-1];
   assign side_out = side_ff[STAGES-1];

endmodule

// ----- hw/rtl/lcse_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_axis
// Back end of one axis: products, 2^k scaling, saturation and acceleration.
// ----------------------------------------------------------------------------
module lcse_axis import lcse_pkg::*; #(
   parameter int DATA_WIDTH = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic [3:0]                       ce,
   input  logic [K_W-1:0]                   k,
   input  logic signed [FRAC_BITS+3:0]      mc,
   input  logic signed [FRAC_BITS+3:0]      ms,
   input  logic signed [DATA_WIDTH-1:0]     pivot,
   input  logic signed [DATA_WIDTH-1:0]     start_vel,
   input  logic signed [DATA_WIDTH:0]       diff,
   input  logic signed [DATA_WIDTH-1:0]     vel_t,
   input  logic signed [DT_W-1:0]           diff_t,
   input  logic [IT_W-1:0]                  inv_time_const_sq,
   output logic signed [DATA_WIDTH-1:0]     pos,
   output logic signed [DATA_WIDTH-1:0]     vel,
   output logic signed [ACC_W-1:0]          acc
);

   localparam int MC_W = FRAC_BITS + 4;
   localparam int DW   = DATA_WIDTH;

   // s * 2^(k-1-FRAC_BITS): floor on right shifts, saturating on left shifts
   function automatic logic signed [WL_W-1:0] scale_k(input logic signed [63:0] s,
                                                      input logic [K_W-1:0] kk);
      int                 sh;
      logic signed [63:0] r;
      logic signed [63:0] lim_sh;
      sh = int'(kk) - 1 - FRAC_BITS;
      if (sh <= 0) begin
         r = s >>> ((-sh > 63) ? 63 : -sh);
      end else if (s == 0) begin
         r = '0;
      end else begin
         lim_sh = (sh >= 38) ? 64'sd0 : (WIDE_LIM >>> sh);
         if (sh >= 38 || s > lim_sh || s < -lim_sh) begin
            r = (s > 0) ? WIDE_LIM : -WIDE_LIM;
         end else begin
            r = s <<< sh;
         end
      end
      if (r > WIDE_LIM) begin
         r = WIDE_LIM;
      end else if (r < -WIDE_LIM) begin
         r = -WIDE_LIM;
      end
      return r[WL_W-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [63:0] v);
      logic signed [63:0] hi;
      hi = (64'sd1 <<< (DW - 1)) - 64'sd1;
      if (v > hi) begin
         return DW'(hi);
      end else if (v < -hi - 64'sd1) begin
         return DW'(-hi - 64'sd1);
      end
      return v[DW-1:0];
   endfunction

   // B1: the four cosh/sinh products
   logic signed [DW+MC_W:0]   pm_ff;
   logic signed [DW+MC_W-1:0] pv_ff;
   logic signed [DT_W+MC_W-1:0] dm_ff;
   logic signed [DW+MC_W-1:0] vm_ff;
   logic [K_W-1:0]            k1_ff;
   logic signed [DW-1:0]      c1_ff;

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         pm_ff <= diff * mc;
         pv_ff <= vel_t * ms;
         dm_ff <= diff_t * ms;
         vm_ff <= start_vel * mc;
         k1_ff <= k;
         c1_ff <= pivot;
      end
   end

   // B2: sums and range scaling
   logic signed [63:0]      sum_p, sum_v;
   logic signed [WL_W-1:0]  dp2_ff, vs2_ff;
   logic signed [DW-1:0]    c2_ff;

   assign sum_p = 64'(pm_ff) + 64'(pv_ff);
   assign sum_v = 64'(dm_ff) + 64'(vm_ff);

   always_ff @(posedge clock) begin
      if (ce[1]) begin
         dp2_ff <= scale_k(sum_p, k1_ff);
         vs2_ff <= scale_k(sum_v, k1_ff);
         c2_ff  <= c1_ff;
      end
   end

   // B3: position, velocity and the acceleration product
   logic signed [DW-1:0] pos3_ff, vel3_ff;
   logic signed [63:0]   accp3_ff;

   always_ff @(posedge clock) begin
      if (ce[2]) begin
         pos3_ff  <= sat_dw(64'(c2_ff) + 64'(dp2_ff));
         vel3_ff  <= sat_dw(64'(vs2_ff));
         accp3_ff <= 64'(dp2_ff) * 64'($signed({1'b0, inv_time_const_sq}));
      end
   end

   // B4: output register
   logic signed [63:0]       acc_sh;
   logic signed [DW-1:0]     pos_ff, vel_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   assign acc_sh = accp3_ff >>> REG_FRAC;

   always_ff @(posedge clock) begin
      if (ce[3]) begin
         pos_ff <= pos3_ff;
         vel_ff <= vel3_ff;
         if (acc_sh > 64'sd2147483647) begin
            acc_ff <= 32'sh7fffffff;
         end else if (acc_sh < -64'sd2147483648) begin
            acc_ff <= 32'sh80000000;
         end else begin
            acc_ff <= acc_sh[ACC_W-1:0];
         end
      end
   end

   assign pos = pos_ff;
   assign vel = vel_ff;
   assign acc = acc_ff;

endmodule

// ----- hw/rtl/lip_com_state_eval.sv -----
`timescale 1ns / 1ps
// Each request passes stages 0 to 3, the CORDIC iterations, B0, then B1 to B4.
// One request is taken per cycle when not stalled; every stage, including each
// CORDIC iteration, owns a register and valid bit; a stall holds only full stages.
// Reset: synchronous, active high; clears all valid bits and loads the register
// defaults (time_const 14800, inv_time_const 290141, inv_time_const_sq 1284506).
// ----------------------------------------------------------------------------
// lip_com_state_eval
// Linear inverted pendulum closed-form state propagation for both axes.
// ----------------------------------------------------------------------------
module lip_com_state_eval import lcse_pkg::*; #(
   parameter int DATA_WIDTH    = 24,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   lcse_req_if.sink             req_ch,
   lcse_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int DW     = DATA_WIDTH;
   localparam int MC_W   = FRAC_BITS + 4;
   localparam int FS     = 4;
   localparam int NST    = FS + CORDIC_STAGES + 5;
   localparam int B0     = FS + CORDIC_STAGES;
   localparam int AX_W   = 4 * DW + 1 + DT_W;
   localparam int SIDE_W = K_W + 2 * AX_W;

   // configuration registers
   logic [TC_W-1:0] tc_ff;
   logic [IT_W-1:0] itc_ff, itsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff   <= TC_RST;
         itc_ff  <= ITC_RST;
         itsq_ff <= ITSQ_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_TIME_CONST:        tc_ff   <= csr_wdata[TC_W-1:0];
            CSR_INV_TIME_CONST:    itc_ff  <= csr_wdata[IT_W-1:0];
            CSR_INV_TIME_CONST_SQ: itsq_ff <= csr_wdata[IT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and the per-stage advance chain
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] ce;
   logic [NST-1:0] vld_prev;

   always_comb begin
      ce[NST-1] = !vld_ff[NST-1] || rsp_ch.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         ce[i] = !vld_ff[i] || ce[i+1];
      end
   end

   assign vld_prev     = {vld_ff[NST-2:0], req_ch.valid};
   assign req_ch.ready = ce[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (ce[i]) begin
               vld_ff[i] <= vld_prev[i];
            end
         end
      end
   end

   // stage 0: capture, time product, position offset
   logic [EL_W+IT_W-1:0]  elp_s0_ff;
   logic signed [DW-1:0]  c_s0_ff [2];
   logic signed [DW-1:0]  v_s0_ff [2];
   logic signed [DW:0]    d_s0_ff [2];

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         elp_s0_ff  <= (EL_W+IT_W)'(req_ch.elapsed) * (EL_W+IT_W)'(itc_ff);
         c_s0_ff[0] <= req_ch.pivot_x;
         c_s0_ff[1] <= req_ch.pivot_y;
         v_s0_ff[0] <= req_ch.start_vel_x;
         v_s0_ff[1] <= req_ch.start_vel_y;
         d_s0_ff[0] <= (DW+1)'(req_ch.start_pos_x) - (DW+1)'(req_ch.pivot_x);
         d_s0_ff[1] <= (DW+1)'(req_ch.start_pos_y) - (DW+1)'(req_ch.pivot_y);
      end
   end

   // stage 1: reciprocal product for k, v0*T and diff/T products
   logic [U_W-1:0]            u_s0;
   logic [U_W-1:0]            u_s1_ff;
   logic [U_W+KDIV_W-1:0]     kp_s1_ff;
   logic signed [DW+16:0]     vtp_s1_ff [2];
   logic signed [DW+25:0]     dtp_s1_ff [2];
   logic signed [DW-1:0]      c_s1_ff [2];
   logic signed [DW-1:0]      v_s1_ff [2];
   logic signed [DW:0]        d_s1_ff [2];

   assign u_s0 = elp_s0_ff[EL_W+IT_W-1:REG_FRAC];

   always_ff @(posedge clock) begin
      if (ce[1]) begin
         u_s1_ff  <= u_s0;
         kp_s1_ff <= (U_W+KDIV_W)'(u_s0) * (U_W+KDIV_W)'(KDIV_MUL);
         for (int a = 0; a < 2; a++) begin
            vtp_s1_ff[a] <= v_s0_ff[a] * $signed({1'b0, tc_ff});
            dtp_s1_ff[a] <= d_s0_ff[a] * $signed({1'b0, itc_ff});
            c_s1_ff[a]   <= c_s0_ff[a];
            v_s1_ff[a]   <= v_s0_ff[a];
            d_s1_ff[a]   <= d_s0_ff[a];
         end
      end
   end

   // stage 2: k estimate times ln2, scaled and clamped velocity terms
   logic [K_W-1:0]        k_s1;
   logic [U_W-1:0]        u_s2_ff;
   logic [K_W-1:0]        k_s2_ff;
   logic [KL_W-1:0]       kl_s2_ff;
   logic signed [DW:0]    vt_full [2];
   logic signed [DW+25:0] dt_full [2];
   logic signed [DW-1:0]  vt_s2_ff [2];
   logic signed [DT_W-1:0] dt_s2_ff [2];
   logic signed [DW-1:0]  c_s2_ff [2];
   logic signed [DW-1:0]  v_s2_ff [2];
   logic signed [DW:0]    d_s2_ff [2];

   assign k_s1 = kp_s1_ff[KDIV_SHIFT+K_W-1:KDIV_SHIFT];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         vt_full[a] = (DW+1)'(vtp_s1_ff[a] >>> REG_FRAC);
         dt_full[a] = dtp_s1_ff[a] >>> REG_FRAC;
      end
   end

   always_ff @(posedge clock) begin
      if (ce[2]) begin
         u_s2_ff  <= u_s1_ff;
         k_s2_ff  <= k_s1;
         kl_s2_ff <= KL_W'(k_s1) * KL_W'(LN2_Q30);
         for (int a = 0; a < 2; a++) begin
            vt_s2_ff[a] <= vt_full[a][DW-1:0];
            if (64'(dt_full[a]) > DT_LIM) begin
               dt_s2_ff[a] <= DT_W'(DT_LIM);
            end else if (64'(dt_full[a]) < -DT_LIM) begin
               dt_s2_ff[a] <= DT_W'(-DT_LIM);
            end else begin
               dt_s2_ff[a] <= dt_full[a][DT_W-1:0];
            end
            c_s2_ff[a] <= c_s1_ff[a];
            v_s2_ff[a] <= v_s1_ff[a];
            d_s2_ff[a] <= d_s1_ff[a];
         end
      end
   end

   // stage 3: residual angle with one correction step
   logic signed [KL_W:0]   r_raw;
   logic signed [Z_W-1:0]  z_s3_ff;
   logic [K_W-1:0]         k_s3_ff;
   logic [AX_W-1:0]        ax_s3_ff [2];

   assign r_raw = $signed({1'b0, KL_W'({u_s2_ff, (ANG_FRAC - REG_FRAC)'(0)})})
                  - $signed({1'b0, kl_s2_ff});

   always_ff @(posedge clock) begin
      if (ce[3]) begin
         if (64'(r_raw) >= LN2_Q30) begin
            z_s3_ff <= Z_W'(64'(r_raw) - LN2_Q30);
            k_s3_ff <= k_s2_ff + K_W'(1);
         end else begin
            z_s3_ff <= Z_W'(r_raw);
            k_s3_ff <= k_s2_ff;
         end
         for (int a = 0; a < 2; a++) begin
            ax_s3_ff[a] <= {c_s2_ff[a], v_s2_ff[a], d_s2_ff[a], vt_s2_ff[a], dt_s2_ff[a]};
         end
      end
   end

   // CORDIC iterations
   logic signed [Z_W-1:0] cx, cy;
   logic [SIDE_W-1:0]     side_out;

   lcse_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE_W)
   ) u_cordic (
      .clock    (clock),
      .ce       (ce[B0-1:FS]),
      .z_in     (z_s3_ff),
      .side_in  ({k_s3_ff, ax_s3_ff[0], ax_s3_ff[1]}),
      .x_out    (cx),
      .y_out    (cy),
      .side_out (side_out)
   );

   // B0: undo range reduction into cosh/sinh mantissas
   logic signed [Z_W:0]   ep, dxy, en;
   logic signed [Z_W+1:0] sum_c, sum_s, mc_full, ms_full;
   logic [5:0]            en_sh;
   logic [K_W-1:0]        k_c;
   logic signed [MC_W-1:0] mc_ff, ms_ff;
   logic [K_W-1:0]        k_b0_ff;
   logic [AX_W-1:0]       ax_b0_ff [2];

   assign k_c   = side_out[SIDE_W-1 -: K_W];
   assign ep    = (Z_W+1)'(cx) + (Z_W+1)'(cy);
   assign dxy   = (Z_W+1)'(cx) - (Z_W+1)'(cy);
   assign en_sh = (k_c >= K_W'(Z_W / 2)) ? 6'(Z_W) : 6'({k_c, 1'b0});
   assign en    = dxy >>> en_sh;
   assign sum_c = (Z_W+2)'(ep) + (Z_W+2)'(en);
   assign sum_s = (Z_W+2)'(ep) - (Z_W+2)'(en);
   assign mc_full = sum_c >>> (ANG_FRAC - FRAC_BITS);
   assign ms_full = sum_s >>> (ANG_FRAC - FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ce[B0]) begin
         mc_ff       <= mc_full[MC_W-1:0];
         ms_ff       <= ms_full[MC_W-1:0];
         k_b0_ff     <= k_c;
         ax_b0_ff[0] <= side_out[2*AX_W-1 -: AX_W];
         ax_b0_ff[1] <= side_out[AX_W-1:0];
      end
   end

   // per-axis back end
   logic signed [DW-1:0]    pos_o [2];
   logic signed [DW-1:0]    vel_o [2];
   logic signed [ACC_W-1:0] acc_o [2];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      lcse_axis #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_axis (
         .clock             (clock),
         .ce                (ce[NST-1:B0+1]),
         .k                 (k_b0_ff),
         .mc                (mc_ff),
         .ms                (ms_ff),
         .pivot             (ax_b0_ff[a][AX_W-1 -: DW]),
         .start_vel         (ax_b0_ff[a][AX_W-DW-1 -: DW]),
         .diff              (ax_b0_ff[a][AX_W-2*DW-1 -: DW+1]),
         .vel_t             (ax_b0_ff[a][DT_W+DW-1 -: DW]),
         .diff_t            (ax_b0_ff[a][DT_W-1:0]),
         .inv_time_const_sq (itsq_ff),
         .pos               (pos_o[a]),
         .vel               (vel_o[a]),
         .acc               (acc_o[a])
      );
   end

   assign rsp_ch.valid = vld_ff[NST-1];
   assign rsp_ch.pos_x = pos_o[0];
   assign rsp_ch.pos_y = pos_o[1];
   assign rsp_ch.vel_x = vel_o[0];
   assign rsp_ch.vel_y = vel_o[1];
   assign rsp_ch.acc_x = acc_o[0];
   assign rsp_ch.acc_y = acc_o[1];

endmodule

// ----- hw/rtl/lcse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcse_checker
// Port-level checks of the evaluator's request/response behavior.
// ----------------------------------------------------------------------------
`include "lip_com_state_eval_defines.svh"

module lcse_checker import lcse_pkg::*; #(
   parameter int DATA_WIDTH = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_pos_x,
   input logic signed [ACC_W-1:0]      rsp_acc_x
);

   // a stalled response stays offered, with pos_x and acc_x unchanged
   `LCSE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response dropped while stalled")
   `LCSE_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_pos_x) && $stable(rsp_acc_x), "stalled response changed")

   // an empty output stage never blocks a request
   `LCSE_ASSERT_IMP(a_req_free, clock, reset, !rsp_valid, req_ready,
      "request blocked with empty output")

   // pipeline comes out of reset empty
   `LCSE_ASSERT_NXT(a_rst_empty, clock, 1'b0, reset, !rsp_valid,
      "response right after reset")

endmodule

bind lip_com_state_eval lcse_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_lcse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pos_x (rsp_ch.pos_x),
   .rsp_acc_x (rsp_ch.acc_x)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pendulum state evaluator against a cycle-free predictor of the
// closed form, with random stalls on both channels and several register sets.
// ----------------------------------------------------------------------------

module testbench;
   import lcse_pkg::*;

   localparam int DW = 24;
   localparam int STAGES = 18;
   localparam int LATENCY = STAGES + 9;
   localparam longint WLIM = (64'sd1 <<< 38) - 1;
   localparam longint DLIM = (64'sd1 <<< 34) - 1;

   typedef struct packed {
      logic signed [23:0] pos_x, pos_y, vel_x, vel_y;
      logic signed [31:0] acc_x, acc_y;
   } state_type;

   // expected responses, one per accepted request
   class lip_tracker;
      state_type pending[$];
      int        errors;

      function void note_request(state_type s);
         pending.insert(pending.size(), s);
      endfunction

      function void check_response(state_type got);
         state_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with none pending, got %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.pos_x !== got.pos_x) begin
            $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, got.pos_x); errors++; end
         if (want.pos_y !== got.pos_y) begin
            $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, got.pos_y); errors++; end
         if (want.vel_x !== got.vel_x) begin
            $display("%0t: vel_x exp %0d got %0d", $time, want.vel_x, got.vel_x); errors++; end
         if (want.vel_y !== got.vel_y) begin
            $display("%0t: vel_y exp %0d got %0d", $time, want.vel_y, got.vel_y); errors++; end
         if (want.acc_x !== got.acc_x) begin
            $display("%0t: acc_x exp %0d got %0d", $time, want.acc_x, got.acc_x); errors++; end
         if (want.acc_y !== got.acc_y) begin
            $display("%0t: acc_y exp %0d got %0d", $time, want.acc_y, got.acc_y); errors++; end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   lcse_req_if #(.DATA_WIDTH(DW)) req_ch ();
   lcse_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   lip_com_state_eval dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   lip_tracker tracker = new();

   // predictor copy of the registers
   longint tc_reg = 14800, itc_reg = 290141, itsq_reg = 1284506;

   bit hold_long = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor shift
   function automatic longint shr(longint v, int s);
      if (s <= 0) return v;
      if (s >= 63) return v < 0 ? -1 : 0;
      return v >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint sat_bits(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint atanh_q30(int i);
      case (i)
         1: return 589812981;
         2: return 274247419;
         3: return 134923406;
         4: return 67196451;
         5: return 33565361;
         6: return 16778582;
         7: return 8388779;
         8: return 4194325;
         9: return 2097155;
         default: return (i > 30) ? 0 : (64'sd1 <<< (30 - i));
      endcase
   endfunction

   // multiply by 2^(k-17), saturating the wide term
   function automatic longint scale_pow2(longint s, longint k);
      longint sh, r;
      sh = k - 17;
      if (sh <= 0) r = shr(s, sh < -63 ? 63 : int'(-sh));
      else if (s == 0) r = 0;
      else if (sh >= 38 || s > (WLIM >>> sh) || s < -(WLIM >>> sh))
         r = s > 0 ? WLIM : -WLIM;
      else r = s <<< sh;
      return clamp(r, WLIM);
   endfunction

   function automatic void predict_axis(input longint p0, v0, c, k, mc, ms,
                                        output longint pos, vel, acc);
      longint diff, vt, dp, dt;
      diff = p0 - c;
      vt = shr(v0 * tc_reg, 16);
      dp = scale_pow2(diff * mc + vt * ms, k);
      dt = clamp(shr(diff * itc_reg, 16), DLIM);
      pos = sat_bits(c + dp, DW);
      vel = sat_bits(scale_pow2(dt * ms + v0 * mc, k), DW);
      acc = sat_bits(shr(dp * itsq_reg, 16), 32);
   endfunction

   function automatic state_type predict_state(
         longint px, py, vx, vy, cx, cy, longint el);
      state_type s;
      longint u16, z30, k, x, y, z, dx, dy, ep, en, mc, ms;
      longint p, v, a;
      int idx, rep;
      bit again;
      u16 = (el * itc_reg) >>> 16;
      z30 = u16 <<< 14;
      k = z30 / 744261118;
      z = z30 - k * 744261118;
      x = 1296540104; y = 0;
      idx = 1; rep = 4; again = 0;
      for (int n = 0; n < STAGES; n++) begin
         dx = shr(y, idx); dy = shr(x, idx);
         if (z >= 0) begin x += dx; y += dy; z -= atanh_q30(idx); end
         else begin x -= dx; y -= dy; z += atanh_q30(idx); end
         if (idx == rep && !again) again = 1;
         else begin
            if (idx == rep) begin rep = 3 * rep + 1; again = 0; end
            idx++;
         end
      end
      ep = x + y;
      en = shr(x - y, k >= 32 ? 63 : int'(2 * k));
      mc = shr(ep + en, 14);
      ms = shr(ep - en, 14);
      predict_axis(px, vx, cx, k, mc, ms, p, v, a);
      s.pos_x = 24'(p); s.vel_x = 24'(v); s.acc_x = 32'(a);
      predict_axis(py, vy, cy, k, mc, ms, p, v, a);
      s.pos_y = 24'(p); s.vel_y = 24'(v); s.acc_y = 32'(a);
      return s;
   endfunction

   // note each accepted request, check each accepted response
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         tracker.note_request(predict_state(req_ch.start_pos_x, req_ch.start_pos_y,
            req_ch.start_vel_x, req_ch.start_vel_y, req_ch.pivot_x, req_ch.pivot_y,
            req_ch.elapsed));
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_response({rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.vel_x,
            rsp_ch.vel_y, rsp_ch.acc_x, rsp_ch.acc_y});
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // receiver: random stalls, and one long hold once hold_long is set
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long && !held) begin
            rsp_ch.ready <= 1'b0;
            for (n = 0; n < 200; n++) @(posedge clock);
            held = 1'b1;
         end
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         @(posedge clock);
         if ($urandom_range(0, 49) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = pick_gap();
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input csr_idx_type idx, input longint val);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val[23:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TIME_CONST: tc_reg = val & 64'hFFFF;
         CSR_INV_TIME_CONST: itc_reg = val & 64'hFFFFFF;
         default: itsq_reg = val & 64'hFFFFFF;
      endcase
   endtask

   task automatic send_request(input logic [23:0] px, py, vx, vy, cx, cy,
                               input logic [16:0] el, input bit gaps);
      int g;
      req_ch.valid <= 1'b1;
      req_ch.start_pos_x <= px; req_ch.start_pos_y <= py;
      req_ch.start_vel_x <= vx; req_ch.start_vel_y <= vy;
      req_ch.pivot_x <= cx; req_ch.pivot_y <= cy; req_ch.elapsed <= el;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (gaps) begin
         g = pick_gap();
         if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom());
         default: return 24'($signed($urandom_range(0, 262143)) - 131072);
      endcase
   endfunction

   function automatic logic [16:0] rand_elapsed();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 17'd65536;
         2: return 17'($urandom_range(0, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic random_phase(input int count, input bit gaps);
      for (int i = 0; i < count; i++)
         send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_elapsed(), gaps);
   endtask

   // stimulus
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.start_pos_x <= '0; req_ch.start_pos_y <= '0;
      req_ch.start_vel_x <= '0; req_ch.start_vel_y <= '0;
      req_ch.pivot_x <= '0; req_ch.pivot_y <= '0; req_ch.elapsed <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero elapsed, full elapsed, mixed signs
      send_request(0, 0, 0, 0, 0, 0, 0, 0);
      send_request(24'h010000, 24'hFF0000, 24'h008000, 24'hFF8000, 0, 0, 0, 0);
      send_request(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
         24'h800000, 24'h7FFFFF, 17'd65536, 0);
      send_request(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
         24'h7FFFFF, 24'h800000, 17'h1FFFF, 0);
      send_request(24'h00A000, 24'hFF6000, 24'h004000, 24'h000000,
         24'h002000, 24'hFFE000, 17'd3277, 1);
      send_request(24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0, 17'd1, 1);
      send_request(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
         0, 0, 17'd32768, 1);
      send_request(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
         24'h555555, 24'hAAAAAA, 17'h0AAAA, 0);
      wait_drained();

      // receiver holds off long while the sender keeps offering
      hold_long = 1'b1;
      random_phase(120, 0);
      wait_drained();
      random_phase(400, 1);
      wait_drained();

      // register extremes: tiny T with huge reciprocals drives the saturation paths
      write_reg(CSR_TIME_CONST, 1);
      write_reg(CSR_INV_TIME_CONST, 24'hFFFFFF);
      write_reg(CSR_INV_TIME_CONST_SQ, 24'hFFFFFF);
      random_phase(150, 1);
      wait_drained();

      write_reg(CSR_TIME_CONST, 16'hFFFF);
      write_reg(CSR_INV_TIME_CONST, 1);
      write_reg(CSR_INV_TIME_CONST_SQ, 1);
      random_phase(150, 1);
      wait_drained();

      // moderate random settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_TIME_CONST, $urandom_range(1, 65535));
         write_reg(CSR_INV_TIME_CONST, $urandom_range(1, 1 << 20));
         write_reg(CSR_INV_TIME_CONST_SQ, $urandom_range(1, 24'hFFFFFF));
         random_phase(150, ph[0]);
         wait_drained();
      end

      write_reg(CSR_TIME_CONST, 14800);
      write_reg(CSR_INV_TIME_CONST, 290141);
      write_reg(CSR_INV_TIME_CONST_SQ, 1284506);
      random_phase(170, 1);
      wait_drained();

      if (tracker.errors == 0)
         $display("lip_com_state_eval verification clean");
      else
         $display("lip_com_state_eval verification failed");
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("lip_com_state_eval verification failed");
      $finish;
   end
endmodule

// ----- lip_com_state_eval.f -----
+incdir+hw/rtl
hw/rtl/lcse_pkg.sv
hw/rtl/lcse_req_if.sv
hw/rtl/lcse_rsp_if.sv
hw/rtl/lcse_cordic.sv
hw/rtl/lcse_axis.sv
hw/rtl/lip_com_state_eval.sv
hw/rtl/lcse_checker.sv
tb/sv/testbench.sv
